// ----- sv/imdu_pkg.sv -----
// Shared types and constants of the integer multiply/divide unit.
`timescale 1ns / 1ps
`default_nettype none

package imdu_pkg;

	// Operand and result width.
	localparam int DATA_WIDTH = 32;
	// Step counter width, enough to index every bit of a word.
	localparam int CNT_W = $clog2(DATA_WIDTH);
	// Command field width.
	localparam int CMD_W = 3;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_MUL  = 3'd0,
		CMD_SDIV = 3'd1,
		CMD_UDIV = 3'd2,
		CMD_SREM = 3'd3,
		CMD_UREM = 3'd4
	} cmd_t;

	// Work the shared adder does in a given cycle.
	typedef enum logic [2:0] {
		PH_NONE = 3'd0,
		PH_NEGA = 3'd1,
		PH_NEGB = 3'd2,
		PH_STEP = 3'd3,
		PH_POST = 3'd4
	} phase_t;

	// Sequencer to datapath control.
	typedef struct packed {
		logic   load;
		phase_t phase;
	} ctl_t;

endpackage

`default_nettype wire

// ----- sv/imdu_core.sv -----
// Datapath of the multiply/divide unit: operand registers around one shared adder.
`timescale 1ns / 1ps
`default_nettype none

module imdu_core (
	input  wire logic                            clk,
	input  wire imdu_pkg::ctl_t                  ctl,
	input  wire logic [imdu_pkg::CMD_W-1:0]      cmd_in,
	input  wire logic [imdu_pkg::DATA_WIDTH-1:0] a_in,
	input  wire logic [imdu_pkg::DATA_WIDTH-1:0] b_in,
	output logic      [imdu_pkg::DATA_WIDTH-1:0] res
);

	localparam int W = imdu_pkg::DATA_WIDTH;

	// acc_q: product accumulator or partial remainder
	// quo_q: multiplier / dividend, shifting into quotient
	// dvs_q: multiplicand / divisor
	logic [W-1:0]                 acc_q;
	logic [W-1:0]                 quo_q;
	logic [W-1:0]                 dvs_q;
	logic [W-1:0]                 res_q;
	logic [imdu_pkg::CMD_W-1:0]   cmd_q;
	logic                         sa_q;
	logic                         sb_q;

	logic [W:0]   add_x;
	logic [W:0]   add_y;
	logic         add_sub;
	logic [W+1:0] sum;
	logic         carry;
	logic         is_mul;
	logic         is_signed_in;

	assign is_mul       = (cmd_q == imdu_pkg::CMD_MUL);
	assign is_signed_in = (cmd_in == imdu_pkg::CMD_SDIV) || (cmd_in == imdu_pkg::CMD_SREM);

	// Shared adder operand selection
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (ctl.phase)
			imdu_pkg::PH_NEGA: begin
				add_y   = {1'b0, quo_q};
				add_sub = 1'b1;
			end
			imdu_pkg::PH_NEGB: begin
				add_y   = {1'b0, dvs_q};
				add_sub = 1'b1;
			end
			imdu_pkg::PH_STEP: begin
				if (is_mul) begin
					add_x = {1'b0, acc_q};
					add_y = quo_q[0] ? {1'b0, dvs_q} : '0;
				end else begin
					add_x   = {acc_q, quo_q[W-1]};
					add_y   = {1'b0, dvs_q};
					add_sub = 1'b1;
				end
			end
			imdu_pkg::PH_POST: begin
				add_y   = (cmd_q == imdu_pkg::CMD_SREM) ? {1'b0, acc_q} : {1'b0, quo_q};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	// One add/subtract, carry out set when no borrow
	assign sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+2)'(add_sub);
	assign carry = sum[W+1];

	// Register updates
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
			quo_q <= a_in;
			dvs_q <= b_in;
			cmd_q <= cmd_in;
			sa_q  <= is_signed_in & a_in[W-1];
			sb_q  <= is_signed_in & b_in[W-1];
		end else begin
			unique case (ctl.phase)
				imdu_pkg::PH_NEGA: begin
					if (sa_q) quo_q <= sum[W-1:0];
				end
				imdu_pkg::PH_NEGB: begin
					if (sb_q) dvs_q <= sum[W-1:0];
				end
				imdu_pkg::PH_STEP: begin
					if (is_mul) begin
						acc_q <= sum[W-1:0];
						quo_q <= {1'b0, quo_q[W-1:1]};
						dvs_q <= {dvs_q[W-2:0], 1'b0};
					end else begin
						// restore when the trial subtract borrows
						acc_q <= carry ? sum[W-1:0] : {acc_q[W-2:0], quo_q[W-1]};
						quo_q <= {quo_q[W-2:0], carry};
					end
				end
				imdu_pkg::PH_POST: begin
					unique case (cmd_q)
						imdu_pkg::CMD_MUL:  res_q <= acc_q;
						imdu_pkg::CMD_SDIV: res_q <= (sa_q ^ sb_q) ? sum[W-1:0] : quo_q;
						imdu_pkg::CMD_UDIV: res_q <= quo_q;
						imdu_pkg::CMD_SREM: res_q <= sa_q ? sum[W-1:0] : acc_q;
						imdu_pkg::CMD_UREM: res_q <= acc_q;
						default:            res_q <= '0;
					endcase
				end
				default: begin
					res_q <= res_q;
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ----- sv/integer_multiply_divide_unit.sv -----
// Top level of the integer multiply/divide unit: stream ports and sequencer.
//
// Usage:
//   A request enters on the s_ group: s_tuser carries the command, s_tdata
//   the two operands. The result leaves on the m_ group as one 32-bit word.
//   Commands: multiply low word, signed/unsigned divide, signed/unsigned
//   remainder. Unused command codes return zero.
// Sequence:
//   After a request is taken, the NEGA and NEGB states negate signed operands,
//   the RUN state runs one multiply or restoring divide step for each bit of
//   the word through the shared adder, and the POST state applies the sign
//   fixup and registers the result. All of this runs on one add/subtract
//   unit under the sequencer, so one request is in flight at a time and a
//   new request can be taken at the earliest in the cycle after the result leaves.
// Reset:
//   arst_n clears the sequencer; the unit comes up idle and ready with no
//   result pending.
// Stall:
//   The result holds on m_tdata with m_tvalid high until m_tready; s_tready
//   stays low until then.
`timescale 1ns / 1ps
`default_nettype none

module integer_multiply_divide_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [2*imdu_pkg::DATA_WIDTH-1:0]    s_tdata,  // operand_a, operand_b
	input  wire logic [imdu_pkg::CMD_W-1:0]           s_tuser,  // command
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [imdu_pkg::DATA_WIDTH-1:0]      m_tdata   // result
);

	localparam int W = imdu_pkg::DATA_WIDTH;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_NEGA = 6'b000010,
		ST_NEGB = 6'b000100,
		ST_RUN  = 6'b001000,
		ST_POST = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [imdu_pkg::CNT_W-1:0] cnt_q;
	imdu_pkg::ctl_t             ctl;
	logic                       accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_DONE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_NEGA;
				ST_NEGA: state_q <= ST_NEGB;
				ST_NEGB: begin
					state_q <= ST_RUN;
					cnt_q   <= imdu_pkg::CNT_W'(W - 1);
				end
				ST_RUN: begin
					if (cnt_q == '0) state_q <= ST_POST;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_POST: state_q <= ST_DONE;
				ST_DONE: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath control
	always_comb begin
		ctl.load = accept;
		unique case (state_q)
			ST_NEGA: ctl.phase = imdu_pkg::PH_NEGA;
			ST_NEGB: ctl.phase = imdu_pkg::PH_NEGB;
			ST_RUN:  ctl.phase = imdu_pkg::PH_STEP;
			ST_POST: ctl.phase = imdu_pkg::PH_POST;
			default: ctl.phase = imdu_pkg::PH_NONE;
		endcase
	end

	imdu_core u_core (
		.clk    (clk),
		.ctl    (ctl),
		.cmd_in (s_tuser),
		.a_in   (s_tdata[W-1:0]),
		.b_in   (s_tdata[2*W-1:W]),
		.res    (m_tdata)
	);

	// Checks
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(W + 4) m_tvalid) else $error("result not on time");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_POST))
		else $error("step loop did not finish");

endmodule

`default_nettype wire

// ----- verif/tb_integer_multiply_divide_unit.sv -----
// Testbench for the integer multiply/divide unit: stream stimulus, prediction and result check.
`timescale 1ns / 1ps

module tb_integer_multiply_divide_unit;

	localparam int DATA_WIDTH = imdu_pkg::DATA_WIDTH;
	localparam int CMD_W      = imdu_pkg::CMD_W;

	// Command codes the unit does not define; they must return zero.
	localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam logic [DATA_WIDTH-1:0] MOST_NEGATIVE = 32'h8000_0000;
	localparam logic [DATA_WIDTH-1:0] MINUS_ONE     = 32'hFFFF_FFFF;

	// Cycles with no handshake on either side before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;
	// Cycles to keep watching once nothing is outstanding.
	localparam int TAIL_CYCLES = 40;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [2*DATA_WIDTH-1:0] s_tdata;   // operand_a, operand_b
	logic [CMD_W-1:0]        s_tuser;   // command
	logic                    m_tvalid;
	logic                    m_tready;
	logic [DATA_WIDTH-1:0]   m_tdata;   // result

	logic [DATA_WIDTH-1:0] pending_results[$];
	int                    mismatch_count;
	int                    quiet_cycles;
	bit                    idle_off;

	integer_multiply_divide_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Expected word for one request: low product, quotient or remainder.
	function automatic logic [DATA_WIDTH-1:0] predict_result(
		input logic [CMD_W-1:0]      cmd,
		input logic [DATA_WIDTH-1:0] a,
		input logic [DATA_WIDTH-1:0] b
	);
		logic [DATA_WIDTH-1:0] mag_a, mag_b;
		logic [DATA_WIDTH-1:0] u_quo, u_rem, m_quo, m_rem;
		mag_a = a[DATA_WIDTH-1] ? -a : a;
		mag_b = b[DATA_WIDTH-1] ? -b : b;
		// a zero divisor gives an all-ones quotient magnitude and the dividend as remainder
		u_quo = (b == '0) ? '1 : a / b;
		u_rem = (b == '0) ? a : a % b;
		m_quo = (mag_b == '0) ? '1 : mag_a / mag_b;
		m_rem = (mag_b == '0) ? mag_a : mag_a % mag_b;
		case (cmd)
			imdu_pkg::CMD_MUL:  return a * b;
			imdu_pkg::CMD_SDIV: return (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -m_quo : m_quo;
			imdu_pkg::CMD_UDIV: return u_quo;
			imdu_pkg::CMD_SREM: return a[DATA_WIDTH-1] ? -m_rem : m_rem;
			imdu_pkg::CMD_UREM: return u_rem;
			default:            return '0;
		endcase
	endfunction

	// Mostly defined commands, now and then a spare code.
	function automatic logic [CMD_W-1:0] pick_command();
		case ($urandom_range(0, 31))
			0: return CMD_SPARE_5;
			1: return CMD_SPARE_6;
			2: return CMD_SPARE_7;
			default: begin
				case ($urandom_range(0, 4))
					0: return imdu_pkg::CMD_MUL;
					1: return imdu_pkg::CMD_SDIV;
					2: return imdu_pkg::CMD_UDIV;
					3: return imdu_pkg::CMD_SREM;
					default: return imdu_pkg::CMD_UREM;
				endcase
			end
		endcase
	endfunction

	// Operand classes: small, small negative, boundaries, powers of two, narrowed, full.
	function automatic logic [DATA_WIDTH-1:0] pick_operand();
		logic [DATA_WIDTH-1:0] pow;
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 15);
			1: return -$urandom_range(1, 16);
			2: begin
				case ($urandom_range(0, 5))
					0: return '0;
					1: return 32'd1;
					2: return 32'h7FFF_FFFF;
					3: return MOST_NEGATIVE;
					4: return MINUS_ONE;
					default: return 32'h8000_0001;
				endcase
			end
			3: begin
				pow = 32'd1 << $urandom_range(0, DATA_WIDTH - 1);
				return $urandom_range(0, 1) ? -pow : pow;
			end
			4, 5: return $urandom >> $urandom_range(0, DATA_WIDTH - 1);
			default: return $urandom;
		endcase
	endfunction

	// Present one request, after a random gap unless idling is off, and hold it until taken.
	task automatic send_request(
		input logic [CMD_W-1:0]      cmd,
		input logic [DATA_WIDTH-1:0] a,
		input logic [DATA_WIDTH-1:0] b
	);
		int unsigned gap;
		gap = idle_off ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= CMD_W'($urandom_range(0, 7));
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!s_tready);
	endtask

	// Extremes, every command and each corner case
	task automatic test_directed_cases();
		idle_off = 1'b1;
		send_request(imdu_pkg::CMD_MUL, MINUS_ONE, MINUS_ONE);
		send_request(imdu_pkg::CMD_MUL, MOST_NEGATIVE, 32'd2);
		send_request(imdu_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(imdu_pkg::CMD_MUL, '0, 32'hDEAD_BEEF);
		send_request(imdu_pkg::CMD_SDIV, 32'd7, -32'd2);
		send_request(imdu_pkg::CMD_SDIV, -32'd7, 32'd2);
		send_request(imdu_pkg::CMD_SDIV, MOST_NEGATIVE, MINUS_ONE);
		send_request(imdu_pkg::CMD_SDIV, 32'd1234, '0);
		idle_off = 1'b0;
		send_request(imdu_pkg::CMD_SDIV, -32'd1234, '0);
		send_request(imdu_pkg::CMD_SDIV, '0, '0);
		send_request(imdu_pkg::CMD_UDIV, MINUS_ONE, 32'd1);
		send_request(imdu_pkg::CMD_UDIV, 32'h1234_5678, '0);
		send_request(imdu_pkg::CMD_UDIV, 32'd5, MINUS_ONE);
		send_request(imdu_pkg::CMD_UDIV, MINUS_ONE, MOST_NEGATIVE);
		send_request(imdu_pkg::CMD_SREM, -32'd7, 32'd2);
		send_request(imdu_pkg::CMD_SREM, MOST_NEGATIVE, MINUS_ONE);
		send_request(imdu_pkg::CMD_SREM, -32'd99, '0);
		send_request(imdu_pkg::CMD_SREM, 32'd99, '0);
		send_request(imdu_pkg::CMD_UREM, 32'hCAFE_F00D, '0);
		send_request(imdu_pkg::CMD_UREM, MINUS_ONE, MINUS_ONE);
		send_request(imdu_pkg::CMD_UREM, MINUS_ONE, 32'h7FFF_FFFF);
		send_request(CMD_SPARE_5, MINUS_ONE, MINUS_ONE);
		send_request(CMD_SPARE_6, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(CMD_SPARE_7, 32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	// Random commands over the operand classes
	task automatic test_random_commands(input int count);
		repeat (count) send_request(pick_command(), pick_operand(), pick_operand());
	endtask

	// Zero divisors, most negative over minus one, and unit divisors
	task automatic test_zero_and_overflow(input int count);
		repeat (count) begin
			case ($urandom_range(0, 2))
				0: send_request(pick_command(), pick_operand(), '0);
				1: send_request(pick_command(), MOST_NEGATIVE, MINUS_ONE);
				default: send_request(pick_command(), $urandom,
					$urandom_range(0, 1) ? MINUS_ONE : 32'd1);
			endcase
		end
	endtask

	// Full-rate stretch with neither side idling
	task automatic test_back_to_back(input int count);
		idle_off = 1'b1;
		repeat (count) send_request(pick_command(), pick_operand(), pick_operand());
		idle_off = 1'b0;
	endtask

	// Result side: random stall per result unless idling is off, sometimes held while a result waits
	initial begin : result_sink
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, 17);
			@(negedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				if ($urandom_range(0, 1) == 1) begin
					do @(posedge clk); while (!m_tvalid);
				end
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Predict on each accepted request, check each accepted result, watch for hangs
	always @(posedge clk) begin : result_monitor
		logic [DATA_WIDTH-1:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.push_back(predict_result(s_tuser, s_tdata[DATA_WIDTH-1:0],
					s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result %h with no request outstanding", $realtime, m_tdata);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want) begin
						if (mismatch_count < 10)
							$display("%0t: result mismatch, expected %h, got %h",
								$realtime, want, m_tdata);
						mismatch_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Reset, run the tests in turn, drain and report
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = imdu_pkg::CMD_MUL;
		idle_off       = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_commands(1400);
		test_zero_and_overflow(200);
		test_back_to_back(326);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- integer_multiply_divide_unit.f -----
sv/imdu_pkg.sv
sv/imdu_core.sv
sv/integer_multiply_divide_unit.sv
verif/tb_integer_multiply_divide_unit.sv
